/* sv/fnds_pkg.sv */
// Package for the fractional-N divider solver: result layout, divider
// request and response types, fixed frequency constants, register indices and power codes.
// No dependencies.
`default_nettype none
package fnds_pkg;

  localparam int unsigned DIV_NW = 57;
  localparam int unsigned DIV_DW = 30;

  localparam logic [32:0] VCO_MIN_HZ = 33'd2200000000;
  localparam logic [32:0] PRESC_SWITCH_HZ = 33'd3000000000;
  localparam logic [27:0] DOUBLER_MAX_REF_HZ = 28'd12500000;
  localparam logic [6:0] MIN_N_PRESC45 = 7'd23;
  localparam logic [6:0] MIN_N_PRESC89 = 7'd75;
  localparam logic [32:0] P5_LOW_HZ = 33'd50000000;
  localparam logic [32:0] P5_HIGH_HZ = 33'd1400000000;
  localparam logic [32:0] P2_LOW_HZ = 33'd1400000000;
  localparam logic [32:0] P2_HIGH_HZ = 33'd2200000000;

  localparam logic [1:0] CFG_REF_FREQ = 2'd0;
  localparam logic [1:0] CFG_PFD_LIMIT = 2'd1;
  localparam logic [1:0] CFG_BAND_LIMIT = 2'd2;

  localparam logic [1:0] PWR_PLUS5 = 2'd0;
  localparam logic [1:0] PWR_PLUS2 = 2'd1;
  localparam logic [1:0] PWR_DEFAULT = 2'd2;

  typedef struct packed {
    logic        error_flag;
    logic [1:0]  power_code;
    logic [32:0] actual_freq_hz;
    logic [7:0]  band_select_div;
    logic        prescaler_sel;
    logic [2:0]  out_div_log2;
    logic [11:0] frac_value;
    logic [15:0] int_div;
    logic        ref_doubler;
    logic        ref_div2;
    logic [9:0]  r_counter;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

/* sv/fnds_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on fnds_pkg for the request and response types.
`default_nettype none
module fnds_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  fnds_pkg::div_req_t     req_i,
  output fnds_pkg::div_rsp_t     rsp_o
);

  localparam int unsigned NW = fnds_pkg::DIV_NW;
  localparam int unsigned DW = fnds_pkg::DIV_DW;
  localparam int unsigned CW = $clog2(NW);

  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    diff = trial - {1'b0, den_q};
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d = req_i.num;
      den_d = req_i.den;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DW-1:0];
        num_d = {num_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        num_d = {num_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem = rem_q;

endmodule
`default_nettype wire

/* sv/frac_n_pll_divider_solver_unit.sv */
// Top level of the fractional-N divider solver: configuration registers,
// search sequencer and result register. Depends on fnds_pkg and fnds_div.
//
// Channel  Direction  Handshake                Contents
// s_axis   in         s_axis_tvalid/tready     target frequency in hertz
// m_axis   out        m_axis_tvalid/tready     divider settings and error flag
// cfg      in         cfg_valid_i/cfg_ready_o  register index and value
//
// One transaction doubles the target k times to scale the VCO, runs a setup step, tries
// R values in turn up to R_MAX, runs three divider passes, a multiply step and a fourth
// divider pass, and then loads the result. Reset is asynchronous and active low and
// loads the default register values. The input is taken only while the sequencer is
// idle; a finished result waits in the output register until it is taken.
`default_nettype none
module frac_n_pll_divider_solver_unit #(
  parameter int unsigned R_MAX = 1023,
  parameter int unsigned BAND_DIV_MAX = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // target_freq_hz[32:0], zero pad
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // r_counter, ref_div2, ref_doubler, int_div, frac_value, out_div_log2,
  // prescaler_sel, band_select_div, actual_freq_hz, power_code, error_flag
  output      logic [87:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [27:0] cfg_data_i
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_NORM   = 10'b0000000010,
    ST_PREP   = 10'b0000000100,
    ST_SEARCH = 10'b0000001000,
    ST_DIV_N  = 10'b0000010000,
    ST_DIV_F  = 10'b0000100000,
    ST_DIV_B  = 10'b0001000000,
    ST_MUL    = 10'b0010000000,
    ST_DIV_A  = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [27:0] ref_q;
  logic [26:0] pfd_q;
  logic [19:0] bcl_q;

  logic [32:0] vco_q, vco_d;
  logic [2:0]  k_q, k_d;
  logic        presc_q, presc_d;
  logic        dbl_q, dbl_d;
  logic [28:0] refd_q, refd_d;
  logic [35:0] minref_q, minref_d;
  logic [27:0] bclb_q, bclb_d;
  logic [9:0]  r_q, r_d;
  logic [42:0] vcor_q, vcor_d;
  logic [36:0] pfdr_q, pfdr_d;
  logic [29:0] lim_q, lim_d;
  logic [37:0] limb_q, limb_d;
  logic [15:0] n_q, n_d;
  logic [11:0] frac_q, frac_d;
  logic [7:0]  bs_q, bs_d;
  logic [32:0] act_q, act_d;
  logic        err_q, err_d;

  fnds_pkg::result_t res_q, res_d;
  logic              res_vld_q, res_vld_d;

  fnds_pkg::div_req_t div_req;
  fnds_pkg::div_rsp_t div_rsp;

  logic        dbl_c;
  logic [28:0] refd_c;
  logic [6:0]  min_n_c;
  logic        fits;
  logic [27:0] nf;
  logic [21:0] r4095;
  logic [1:0]  pw;

  fnds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 28'd156250000;
      pfd_q <= 27'd31250000;
      bcl_q <= 20'd125000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fnds_pkg::CFG_REF_FREQ:   ref_q <= cfg_data_i;
        fnds_pkg::CFG_PFD_LIMIT:  pfd_q <= cfg_data_i[26:0];
        fnds_pkg::CFG_BAND_LIMIT: bcl_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dbl_c = (ref_q <= fnds_pkg::DOUBLER_MAX_REF_HZ);
    refd_c = dbl_c ? {ref_q, 1'b0} : {1'b0, ref_q};
    min_n_c = (vco_q > fnds_pkg::PRESC_SWITCH_HZ) ? fnds_pkg::MIN_N_PRESC89
                                                   : fnds_pkg::MIN_N_PRESC45;
    fits = ({8'd0, refd_q} <= pfdr_q) && (vcor_q >= {7'd0, minref_q}) &&
           (bcl_q != 20'd0) && ({9'd0, refd_q} <= limb_q);
    nf = ({n_q, 12'd0} - {12'd0, n_q}) + {16'd0, frac_q};
    r4095 = {r_q, 12'd0} - {12'd0, r_q};
    if (act_q >= fnds_pkg::P2_LOW_HZ && act_q <= fnds_pkg::P2_HIGH_HZ) begin
      pw = fnds_pkg::PWR_PLUS2;
    end else if (act_q >= fnds_pkg::P5_LOW_HZ && act_q <= fnds_pkg::P5_HIGH_HZ) begin
      pw = fnds_pkg::PWR_PLUS5;
    end else begin
      pw = fnds_pkg::PWR_DEFAULT;
    end
  end

  always_comb begin
    state_d = state_q;
    vco_d = vco_q;
    k_d = k_q;
    presc_d = presc_q;
    dbl_d = dbl_q;
    refd_d = refd_q;
    minref_d = minref_q;
    bclb_d = bclb_q;
    r_d = r_q;
    vcor_d = vcor_q;
    pfdr_d = pfdr_q;
    lim_d = lim_q;
    limb_d = limb_q;
    n_d = n_q;
    frac_d = frac_q;
    bs_d = bs_q;
    act_d = act_q;
    err_d = err_q;
    res_d = res_q;
    res_vld_d = res_vld_q;
    div_req = '0;
    if (res_vld_q && m_axis_tready) begin
      res_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          vco_d = s_axis_tdata[32:0];
          k_d = 3'd0;
          err_d = 1'b0;
          if (s_axis_tdata[32:0] == 33'd0 || ref_q == 28'd0) begin
            err_d = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (vco_q < fnds_pkg::VCO_MIN_HZ && k_q != 3'd7) begin
          vco_d = {vco_q[31:0], 1'b0};
          k_d = k_q + 3'd1;
        end else if (k_q == 3'd7) begin
          err_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        presc_d = (vco_q > fnds_pkg::PRESC_SWITCH_HZ);
        dbl_d = dbl_c;
        refd_d = refd_c;
        minref_d = 36'(min_n_c * refd_c);
        bclb_d = 28'(bcl_q * 8'(BAND_DIV_MAX));
        r_d = 10'd1;
        vcor_d = {10'd0, vco_q};
        pfdr_d = {10'd0, pfd_q};
        lim_d = {10'd0, bcl_q};
        limb_d = 38'(bcl_q * 8'(BAND_DIV_MAX));
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (fits) begin
          div_req.start = 1'b1;
          div_req.num = {14'd0, vcor_q};
          div_req.den = {1'b0, refd_q};
          state_d = ST_DIV_N;
        end else if (r_q == 10'(R_MAX)) begin
          err_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          r_d = r_q + 10'd1;
          vcor_d = vcor_q + {10'd0, vco_q};
          pfdr_d = pfdr_q + {10'd0, pfd_q};
          lim_d = lim_q + {10'd0, bcl_q};
          limb_d = limb_q + {10'd0, bclb_q};
        end
      end
      ST_DIV_N: begin
        if (div_rsp.done) begin
          n_d = div_rsp.quot[15:0];
          if (div_rsp.quot[56:16] != '0) begin
            err_d = 1'b1;
            state_d = ST_DONE;
          end else begin
            div_req.start = 1'b1;
            div_req.num = 57'({div_rsp.rem, 12'd0} - {12'd0, div_rsp.rem});
            div_req.den = {1'b0, refd_q};
            state_d = ST_DIV_F;
          end
        end
      end
      ST_DIV_F: begin
        if (div_rsp.done) begin
          frac_d = div_rsp.quot[11:0];
          div_req.start = 1'b1;
          div_req.num = 57'({2'd0, refd_q} + {1'b0, lim_q} - 31'd1);
          div_req.den = lim_q;
          state_d = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (div_rsp.done) begin
          bs_d = div_rsp.quot[7:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV_A;
      end
      ST_DIV_A: begin
        if (div_rsp.done) begin
          act_d = div_rsp.quot[32:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_vld_q || m_axis_tready) begin
          res_d = '0;
          if (err_q) begin
            res_d.error_flag = 1'b1;
          end else begin
            res_d.r_counter = r_q[0] ? r_q : {1'b0, r_q[9:1]};
            res_d.ref_div2 = ~r_q[0];
            res_d.ref_doubler = dbl_q;
            res_d.int_div = n_q;
            res_d.frac_value = frac_q;
            res_d.out_div_log2 = k_q;
            res_d.prescaler_sel = presc_q;
            res_d.band_select_div = bs_q;
            res_d.actual_freq_hz = act_q;
            res_d.power_code = pw;
            res_d.error_flag = 1'b0;
          end
          res_vld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_MUL) begin
      div_req.start = 1'b1;
      div_req.num = 57'(nf * refd_q);
      div_req.den = 30'({8'd0, r4095} << k_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_vld_q <= 1'b0;
      err_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_vld_q <= res_vld_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vco_q <= vco_d;
    k_q <= k_d;
    presc_q <= presc_d;
    dbl_q <= dbl_d;
    refd_q <= refd_d;
    minref_q <= minref_d;
    bclb_q <= bclb_d;
    r_q <= r_d;
    vcor_q <= vcor_d;
    pfdr_q <= pfdr_d;
    lim_q <= lim_d;
    limb_q <= limb_d;
    n_q <= n_d;
    frac_q <= frac_d;
    bs_q <= bs_d;
    act_q <= act_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire
